FILE: hdl/mvul_pkg.sv
// Shared types and constants for the metatile update list generator.
package mvul_pkg;

	localparam logic [15:0] NT_BASE      = 16'h2000;
	localparam logic [7:0]  ATTR_ADDR_HI = 8'h23;   // (0x2000 + 0x3c0) >> 8
	localparam logic [7:0]  ATTR_LO_BASE = 8'hc0;   // low byte of 0x23c0
	localparam logic [7:0]  TILE_HI_OFS  = 8'd16;   // extra offset for codes above 7
	localparam logic [3:0]  TILE_LOW_MAX = 4'd7;

	localparam logic MODE_TILE   = 1'b0;
	localparam logic MODE_SHADOW = 1'b1;

	// list position: cells 0..3 then the attribute triple
	localparam logic [2:0] CELL_ATTR = 3'd4;
	localparam logic [1:0] POS_HI    = 2'd0;
	localparam logic [1:0] POS_LO    = 2'd1;
	localparam logic [1:0] POS_DATA  = 2'd2;

	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);

	localparam int IN_W = 32;

	typedef struct packed {
		logic        mode;
		logic [15:0] addr;   // top-left cell address
		logic [7:0]  tile;   // top-left tile number
		logic [5:0]  aidx;   // attribute shadow index
		logic [1:0]  quad;   // {bottom, right}
		logic [1:0]  pal;
		logic [7:0]  sval;   // shadow preload value
	} mvul_cmd_t;

endpackage

FILE: hdl/mvul_front.sv
// Front end: decodes an incoming transaction into a queued command.
module mvul_front (
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [mvul_pkg::IN_W-1:0] s_tdata,
	input  logic                   s_tuser,
	output logic                   push,
	input  logic                   push_ready,
	output mvul_pkg::mvul_cmd_t    push_cmd
);
	import mvul_pkg::*;

	logic [3:0] grid_x;
	logic [3:0] grid_y;
	logic [3:0] tile_code;
	logic [1:0] palette;
	logic [5:0] shadow_index;
	logic [7:0] shadow_value;
	logic [4:0] sx;
	logic [4:0] sy;
	logic [7:0] tile_lin;

	assign grid_x       = s_tdata[3:0];
	assign grid_y       = s_tdata[7:4];
	assign tile_code    = s_tdata[11:8];
	assign palette      = s_tdata[13:12];
	assign shadow_index = s_tdata[19:14];
	assign shadow_value = s_tdata[27:20];

	assign sx       = {1'b0, grid_x} + 5'd2;
	assign sy       = {1'b0, grid_y} + 5'd1;
	assign tile_lin = {3'b000, tile_code, 1'b0};

	always_comb begin
		push_cmd.mode = s_tuser;
		push_cmd.addr = NT_BASE + {10'd0, sx, 1'b0} + {5'd0, sy, 6'd0};
		push_cmd.tile = (tile_code > TILE_LOW_MAX) ? tile_lin + TILE_HI_OFS : tile_lin;
		push_cmd.quad = {sy[0], sx[0]};
		push_cmd.pal  = palette;
		push_cmd.sval = shadow_value;
		if (s_tuser == MODE_SHADOW) begin
			push_cmd.aidx = shadow_index;
		end else begin
			// row pair * 8 + column pair, wrapped to the table
			push_cmd.aidx = {sy[3:1], 3'b000} + {2'b00, sx[4:1]};
		end
	end

	assign push     = s_tvalid & push_ready;
	assign s_tready = push_ready;

endmodule

FILE: hdl/mvul_queue.sv
// Short command queue between front and back ends.
module mvul_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                push_ready,
	input  mvul_pkg::mvul_cmd_t push_cmd,
	output logic                pop_valid,
	input  logic                pop,
	output mvul_pkg::mvul_cmd_t pop_cmd
);
	import mvul_pkg::*;

	mvul_cmd_t       entry_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_AW:0]   count_q;

	assign push_ready = (count_q != (Q_AW+1)'(Q_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: hdl/mvul_back.sv
// Back end: attribute shadow read-modify-write and list byte serializer.
module mvul_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pop_valid,
	output logic                pop,
	input  mvul_pkg::mvul_cmd_t pop_cmd,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [7:0]          m_tdata,
	output logic                m_tlast
);
	import mvul_pkg::*;

	// attribute shadow, valid bit per entry stands in for the reset clear
	logic [7:0]  shadow_mem [64];
	logic [63:0] shadow_vld_q;
	logic [7:0]  rd_data_q;
	logic        rd_vld_q;

	mvul_cmd_t   cmd_q;
	logic        busy_q;
	logic [2:0]  cell_q;
	logic [1:0]  pos_q;
	logic        wb_s1;
	logic [7:0]  attr_q;

	logic        out_vld_q;
	logic [7:0]  out_byte_q;
	logic        out_last_q;

	logic        load_ok;
	logic        emit;
	logic        is_last;
	logic        pop_shadow;
	logic        pop_tile;
	logic        wr_en;
	logic [5:0]  wr_idx;
	logic [7:0]  wr_data;
	logic [7:0]  rd_val;
	logic [7:0]  keep;
	logic [7:0]  attr_new;
	logic [2:0]  shift;
	logic [15:0] cell_addr;
	logic [7:0]  cell_tile;
	logic [7:0]  next_byte;

	assign load_ok    = !out_vld_q || m_tready;
	assign emit       = busy_q && load_ok;
	assign is_last    = (cell_q == CELL_ATTR) && (pos_q == POS_DATA);
	assign pop        = pop_valid && (!busy_q || (emit && is_last));
	assign pop_shadow = pop && (pop_cmd.mode == MODE_SHADOW);
	assign pop_tile   = pop && (pop_cmd.mode == MODE_TILE);

	// merge palette into its quadrant
	assign rd_val   = rd_vld_q ? rd_data_q : 8'h00;
	assign shift    = {cmd_q.quad, 1'b0};
	assign keep     = ~(8'h03 << shift);
	assign attr_new = (rd_val & keep) | ({6'd0, cmd_q.pal} << shift);

	// single write port: preload at pop, write-back in the cycle after a tile pop
	assign wr_en   = pop_shadow || wb_s1;
	assign wr_idx  = wb_s1 ? cmd_q.aidx : pop_cmd.aidx;
	assign wr_data = wb_s1 ? attr_new : pop_cmd.sval;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			shadow_mem[wr_idx] <= wr_data;
		end
		if (pop_tile) begin
			rd_data_q <= shadow_mem[pop_cmd.aidx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_vld_q <= '0;
			rd_vld_q     <= 1'b0;
		end else begin
			if (wr_en) begin
				shadow_vld_q[wr_idx] <= 1'b1;
			end
			if (pop_tile) begin
				rd_vld_q <= shadow_vld_q[pop_cmd.aidx];
			end
		end
	end

	// list byte for the current position
	assign cell_addr = cmd_q.addr + {10'd0, cell_q[1], 4'd0, cell_q[0]};
	assign cell_tile = cmd_q.tile + {3'd0, cell_q[1], 3'd0, cell_q[0]};

	always_comb begin
		case (pos_q)
			POS_HI:   next_byte = (cell_q == CELL_ATTR) ? ATTR_ADDR_HI : cell_addr[15:8];
			POS_LO:   next_byte = (cell_q == CELL_ATTR) ? (ATTR_LO_BASE | {2'b00, cmd_q.aidx})
			                                            : cell_addr[7:0];
			default:  next_byte = (cell_q == CELL_ATTR) ? attr_q : cell_tile;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= pop_cmd;
		end
		if (wb_s1) begin
			attr_q <= attr_new;
		end
		if (load_ok) begin
			out_byte_q <= next_byte;
			out_last_q <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			cell_q    <= '0;
			pos_q     <= POS_HI;
			wb_s1     <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			wb_s1 <= pop_tile;
			if (load_ok) begin
				out_vld_q <= emit;
			end
			if (pop) begin
				busy_q <= pop_tile;
				cell_q <= '0;
				pos_q  <= POS_HI;
			end else if (emit) begin
				if (is_last) begin
					busy_q <= 1'b0;
				end
				if (pos_q == POS_DATA) begin
					pos_q  <= POS_HI;
					cell_q <= cell_q + 1'b1;
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_byte_q;
	assign m_tlast  = out_last_q;

`ifndef SYNTH
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cell_q <= CELL_ATTR) && (pos_q <= POS_DATA))
		else $error("serializer position out of range");

	a_pop_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (!busy_q || (emit && is_last)))
		else $error("command taken while list still in progress");

	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(wb_s1 && pop_shadow))
		else $error("shadow write-back collides with preload");

	a_wb_follows_tile: assert property (@(posedge clk) disable iff (!arst_n)
		pop_tile |=> wb_s1 && busy_q && (cell_q == 3'd0))
		else $error("write-back not aligned with list start");
`endif

endmodule

FILE: hdl/metatile_vram_update_list_top.sv
// Top level of the metatile video-memory update list generator.
//
// Each mode 0 transaction (a metatile update) produces a 15-byte list on the
// master side: four (address high, address low, tile) triples for the 2x2
// cells in the order top-left, top-right, bottom-left, bottom-right, then the
// attribute byte's address and its new value, with tlast on the fifteenth
// byte. A mode 0 update's bytes leave the single-byte output serializer
// back to back unless m_tready stalls them, and updates stream with no gap
// between lists when the next one is queued. A mode 1 transaction preloads
// one entry of the 64-byte attribute shadow as it is popped and produces no
// bytes. The front end decodes transactions into a 4-entry command queue, so
// the slave side keeps accepting while the back end serializes; a finished
// byte waits in the output register while the next one is prepared. The
// shadow reads as all zeros after reset with no clearing pass (per-entry
// valid bits), and the read-modify-write of an entry completes before the
// next command is started, so updates always see earlier preloads.
module metatile_vram_update_list_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [3:0] grid_x, [7:4] grid_y, [11:8] tile_code, [13:12] palette,
	// [19:14] shadow_index, [27:20] shadow_value, [31:28] zero
	input  logic [31:0] s_tdata,
	// [0] mode
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] list_byte
	output logic [7:0]  m_tdata,
	// list_last
	output logic        m_tlast
);
	import mvul_pkg::*;

	logic      push;
	logic      push_ready;
	mvul_cmd_t push_cmd;
	logic      pop_valid;
	logic      pop;
	mvul_cmd_t pop_cmd;

	mvul_front u_front (
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.push       (push),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	mvul_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_cmd    (pop_cmd)
	);

	mvul_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop       (pop),
		.pop_cmd   (pop_cmd),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

FILE: test/mvul_list_checker.sv
`timescale 1ns / 100ps
// Checker for the metatile update list generator: predicts list bytes and compares them.
module mvul_list_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,
	input  logic        m_tlast,
	output int          fail_count,
	output int          bytes_owed
);
	import mvul_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} list_byte_t;

	list_byte_t owed_list[$];
	logic [7:0] attr_shadow [64];
	int n_fail = 0;
	int n_owed = 0;

	assign fail_count = n_fail;
	assign bytes_owed = n_owed;

	function automatic void owe_triple(input logic [15:0] addr, input logic [7:0] data,
			input logic closes);
		owed_list.push_back({addr[15:8], 1'b0});
		owed_list.push_back({addr[7:0], 1'b0});
		owed_list.push_back({data, closes});
	endfunction

	// one metatile: four cell triples, then the merged attribute byte
	function automatic void predict_update(input logic [3:0] gx, input logic [3:0] gy,
			input logic [3:0] code, input logic [1:0] pal);
		logic [4:0]  sx;
		logic [4:0]  sy;
		logic [15:0] cell_base;
		logic [7:0]  tile;
		logic [5:0]  aidx;
		logic [2:0]  shift;
		logic [7:0]  attr;
		sx = {1'b0, gx} + 5'd2;
		sy = {1'b0, gy} + 5'd1;
		tile = {3'b000, code, 1'b0};
		if (code > TILE_LOW_MAX)
			tile = tile + TILE_HI_OFS;
		cell_base = NT_BASE + {10'b0, sx, 1'b0} + {5'b0, sy, 6'b0};
		owe_triple(cell_base, tile, 1'b0);
		owe_triple(cell_base + 16'd1, tile + 8'd1, 1'b0);
		owe_triple(cell_base + 16'd32, tile + 8'd16, 1'b0);
		owe_triple(cell_base + 16'd33, tile + 8'd17, 1'b0);
		// attribute index wraps at 64 for grids past the play area
		aidx = {sy[3:1], 3'b000} + {2'b00, sx[4:1]};
		shift = {sy[0], sx[0], 1'b0};
		attr = (attr_shadow[aidx] & ~(8'h03 << shift)) | ({6'b0, pal} << shift);
		attr_shadow[aidx] = attr;
		owe_triple({ATTR_ADDR_HI, ATTR_LO_BASE} + {10'b0, aidx}, attr, 1'b1);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		list_byte_t want;
		if (!arst_n) begin
			for (int i = 0; i < 64; i++)
				attr_shadow[i] = 8'h00;
			owed_list.delete();
		end else begin
			if (s_tvalid && s_tready) begin
				if (s_tuser == MODE_SHADOW)
					attr_shadow[s_tdata[19:14]] = s_tdata[27:20];
				else
					predict_update(s_tdata[3:0], s_tdata[7:4], s_tdata[11:8], s_tdata[13:12]);
			end
			if (m_tvalid && m_tready) begin
				if (owed_list.size() == 0) begin
					n_fail++;
					$display("%0t: list byte with none pending, got %02h last %0b",
						$time, m_tdata, m_tlast);
				end else begin
					want = owed_list.pop_front();
					if (m_tdata !== want.data) begin
						n_fail++;
						$display("%0t: list byte expected %02h got %02h",
							$time, want.data, m_tdata);
					end
					if (m_tlast !== want.last) begin
						n_fail++;
						$display("%0t: tlast expected %0b got %0b",
							$time, want.last, m_tlast);
					end
				end
			end
		end
		n_owed <= owed_list.size();
	end

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
// Testbench top for the metatile update list generator: stimulus, flow control and verdict.
module tb;
	import mvul_pkg::*;

	localparam int RAND_ITEMS     = 408;
	localparam int CALM_ITEMS     = 50;    // tail of the run with no idling at all
	localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transaction on either side
	localparam int DRAIN_CYCLES   = 40;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        s_tuser = MODE_TILE;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;

	int   fail_count;
	int   bytes_owed;
	int   quiet_cycles = 0;
	logic calm = 1'b0;

	always #5 clk = ~clk;

	metatile_vram_update_list_top DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	mvul_list_checker list_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.fail_count(fail_count),
		.bytes_owed(bytes_owed)
	);

	// Offer one request on the slave side and hold it until the transaction
	// happens. An optional idle burst before it drops tvalid for a while; when
	// no burst is taken, tvalid simply stays high into the next request.
	task automatic push_request(input logic mode, input logic [3:0] gx, input logic [3:0] gy,
			input logic [3:0] code, input logic [1:0] pal, input logic [5:0] sidx,
			input logic [7:0] sval);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {4'h0, sval, sidx, pal, code, gy, gx};
		do @(posedge clk); while (!s_tready);
	endtask

	// Master side: tready held high for random stretches, dropped for random
	// bursts outside the calm tail so stalls land on every byte of a list.
	initial begin
		forever begin
			if (!calm && $urandom_range(0, 2) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
		end
	end

	// Watchdog: a hung handshake on either side ends the run.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part. Preloads at the index and value extremes, the first with
		// the unused grid fields at their maximum.
		push_request(MODE_SHADOW, 4'd15, 4'd15, 4'd15, 2'd3, 6'd0, 8'h00);
		push_request(MODE_SHADOW, 4'd0, 4'd0, 4'd0, 2'd0, 6'd63, 8'hff);
		push_request(MODE_SHADOW, 4'd0, 4'd0, 4'd0, 2'd0, 6'd1, 8'hff);
		// all four quadrants, code extremes and the low/high code boundary;
		// the first two land on the preloaded entry 1
		push_request(MODE_TILE, 4'd0, 4'd0, 4'd0, 2'd0, 6'd63, 8'hff);
		push_request(MODE_TILE, 4'd1, 4'd0, 4'd7, 2'd3, 6'd0, 8'h00);
		push_request(MODE_TILE, 4'd0, 4'd1, 4'd8, 2'd1, 6'd0, 8'h00);
		push_request(MODE_TILE, 4'd1, 4'd1, 4'd15, 2'd2, 6'd0, 8'h00);
		// far corner of the play area, on the preloaded entry 63
		push_request(MODE_TILE, 4'd13, 4'd13, 4'd15, 2'd3, 6'd0, 8'h00);
		push_request(MODE_TILE, 4'd13, 4'd0, 4'd9, 2'd1, 6'd0, 8'h00);
		push_request(MODE_TILE, 4'd0, 4'd13, 4'd6, 2'd2, 6'd0, 8'h00);
		// past the play area: attribute index wraps, including to entry 0
		push_request(MODE_TILE, 4'd14, 4'd14, 4'd3, 2'd3, 6'd0, 8'h00);
		push_request(MODE_TILE, 4'd15, 4'd15, 4'd12, 2'd2, 6'd0, 8'h00);
		push_request(MODE_TILE, 4'd15, 4'd0, 4'd1, 2'd1, 6'd0, 8'h00);
		push_request(MODE_TILE, 4'd0, 4'd15, 4'd14, 2'd3, 6'd0, 8'h00);
		// same cell, every palette in turn overwrites the same quadrant
		push_request(MODE_TILE, 4'd5, 4'd5, 4'd2, 2'd0, 6'd0, 8'h00);
		push_request(MODE_TILE, 4'd5, 4'd5, 4'd10, 2'd1, 6'd0, 8'h00);
		push_request(MODE_TILE, 4'd5, 4'd5, 4'd11, 2'd2, 6'd0, 8'h00);
		push_request(MODE_TILE, 4'd5, 4'd5, 4'd4, 2'd3, 6'd0, 8'h00);
		// preload directly followed by an update of the same entry
		push_request(MODE_SHADOW, 4'd0, 4'd0, 4'd0, 2'd0, 6'd9, 8'h5a);
		push_request(MODE_TILE, 4'd0, 4'd1, 4'd5, 2'd0, 6'd9, 8'ha5);
		push_request(MODE_TILE, 4'd6, 4'd7, 4'd13, 2'd2, 6'd42, 8'h3c);

		// Random part: mostly updates inside the play area, some past it, and
		// about a quarter preloads so updates keep meeting loaded entries.
		for (int n = 0; n < RAND_ITEMS; n++) begin
			calm = (n >= RAND_ITEMS - CALM_ITEMS);
			if ($urandom_range(0, 3) == 0)
				push_request(MODE_SHADOW, 4'($urandom), 4'($urandom), 4'($urandom),
					2'($urandom), 6'($urandom), 8'($urandom));
			else if ($urandom_range(0, 4) == 0)
				push_request(MODE_TILE, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
					4'($urandom), 2'($urandom), 6'($urandom), 8'($urandom));
			else
				push_request(MODE_TILE, 4'($urandom_range(0, 13)), 4'($urandom_range(0, 13)),
					4'($urandom), 2'($urandom), 6'($urandom), 8'($urandom));
		end
		s_tvalid <= 1'b0;
		// let the checker's pending count take in the last transaction
		@(posedge clk);

		// drain the lists still in flight, then let the back end settle
		while (bytes_owed != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
